// ===== rtl/sliding_trimmed_mean_filter_defines.svh =====
// Assertion macros used by the filter's top-level RTL file.
`ifndef SLIDING_TRIMMED_MEAN_FILTER_DEFINES_SVH
`define SLIDING_TRIMMED_MEAN_FILTER_DEFINES_SVH

`ifndef SYNTHESIS
`define STMF_ASSERT_NOW(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("assertion failed");
`define STMF_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("assertion failed");
`else
`define STMF_ASSERT_NOW(label, clk, rst_n, cond, expr)
`define STMF_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

// ===== rtl/stmf_pkg.sv =====
// Types and constants shared by the trimmed mean filter modules.
package stmf_pkg;

  localparam int DEF_WINDOW      = 16;
  localparam int DEF_SAMPLE_BITS = 16;
  localparam int FRAC_BITS       = 8;
  localparam int OUT_W           = 24;
  localparam int TRIM_W          = 3;
  localparam int TRIM_MAX        = 7;
  localparam int CFG_AW          = 3;
  localparam int CFG_DW          = 32;

  localparam logic REG_TRIM = 1'b0;
  localparam logic REG_FILL = 1'b1;

  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic fill;
    logic rd;
    logic upd;
    logic load;
    logic shift;
  } stmf_ctl_t;

endpackage

// ===== rtl/stmf_window.sv =====
// Ring window memory with write slot, running sum and fill sweep.
module stmf_window #(
  parameter int WINDOW      = stmf_pkg::DEF_WINDOW,
  parameter int SAMPLE_BITS = stmf_pkg::DEF_SAMPLE_BITS,
  parameter int SUM_W       = SAMPLE_BITS + $clog2(WINDOW) + 1
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  stmf_pkg::stmf_ctl_t           ctl,
  input  logic signed [SAMPLE_BITS-1:0] fill_value,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic signed [SAMPLE_BITS-1:0] old_sample,
  output logic signed [SUM_W-1:0]       sum,
  output logic                          fill_busy
);
  import stmf_pkg::*;

  localparam int AW = $clog2(WINDOW);

  logic signed [SAMPLE_BITS-1:0] mem [WINDOW];
  logic signed [SAMPLE_BITS-1:0] rdata_r;
  logic [AW-1:0]                 slot_r;
  logic [AW-1:0]                 sweep_idx_r;
  logic                          sweep_r;
  logic signed [SUM_W-1:0]       sum_r;
  logic signed [SUM_W-1:0]       sum_fill;
  logic signed [SUM_W-1:0]       sum_upd;
  logic                          we;
  logic [AW-1:0]                 waddr;
  logic signed [SAMPLE_BITS-1:0] wdata;

  assign sum_fill = SUM_W'(SUM_W'(fill_value) * SUM_W'(WINDOW));
  assign sum_upd  = sum_r - SUM_W'(rdata_r) + SUM_W'(sample);
  assign we       = sweep_r | ctl.upd;
  assign waddr    = sweep_r ? sweep_idx_r : slot_r;
  assign wdata    = sweep_r ? fill_value : sample;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.rd) begin
      rdata_r <= mem[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (sweep_r) begin
      sum_r <= sum_fill;
    end else if (ctl.upd) begin
      sum_r <= sum_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= 1'b1;
      sweep_idx_r <= '0;
      slot_r      <= '0;
    end else begin
      if (ctl.fill) begin
        sweep_r     <= 1'b1;
        sweep_idx_r <= '0;
      end else if (sweep_r) begin
        if (sweep_idx_r == AW'(WINDOW - 1)) begin
          sweep_r <= 1'b0;
        end
        sweep_idx_r <= sweep_idx_r + 1'b1;
      end
      if (ctl.upd) begin
        slot_r <= (slot_r == AW'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
      end
    end
  end

  assign old_sample = rdata_r;
  assign sum        = sum_r;
  assign fill_busy  = sweep_r;

endmodule

// ===== rtl/stmf_sort.sv =====
// Sorted sample row with combinational remove-and-insert replace and the two trim scan chains.
module stmf_sort #(
  parameter int WINDOW      = stmf_pkg::DEF_WINDOW,
  parameter int SAMPLE_BITS = stmf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  stmf_pkg::stmf_ctl_t           ctl,
  input  logic                          fill_busy,
  input  logic signed [SAMPLE_BITS-1:0] fill_value,
  input  logic signed [SAMPLE_BITS-1:0] old_sample,
  input  logic signed [SAMPLE_BITS-1:0] new_sample,
  output logic signed [SAMPLE_BITS-1:0] lo_head,
  output logic signed [SAMPLE_BITS-1:0] hi_head
);
  import stmf_pkg::*;

  localparam int TrimLim = (WINDOW - 1) / 2;
  localparam int Scan    = (TrimLim < TRIM_MAX) ? TrimLim : TRIM_MAX;

  logic signed [SAMPLE_BITS-1:0] row_r   [WINDOW];
  logic signed [SAMPLE_BITS-1:0] rem_v   [WINDOW];
  logic signed [SAMPLE_BITS-1:0] row_nxt [WINDOW];
  logic signed [SAMPLE_BITS-1:0] lo_r    [Scan];
  logic signed [SAMPLE_BITS-1:0] hi_r    [Scan];
  logic [WINDOW-1:0]             ge_old;
  logic [WINDOW-1:0]             gt_new;

  // Drop one copy of the old sample, then insert the new one in order.
  always_comb begin
    for (int k = 0; k < WINDOW; k++) begin
      ge_old[k] = row_r[k] >= old_sample;
    end
    for (int k = 0; k < WINDOW - 1; k++) begin
      rem_v[k] = ge_old[k] ? row_r[k+1] : row_r[k];
    end
    rem_v[WINDOW-1] = row_r[WINDOW-1];
    for (int k = 0; k < WINDOW - 1; k++) begin
      gt_new[k] = rem_v[k] > new_sample;
    end
    gt_new[WINDOW-1] = ge_old[WINDOW-1] | 1'b1;
    row_nxt[0] = gt_new[0] ? new_sample : rem_v[0];
    for (int k = 1; k < WINDOW; k++) begin
      if (!gt_new[k]) begin
        row_nxt[k] = rem_v[k];
      end else if (!gt_new[k-1]) begin
        row_nxt[k] = new_sample;
      end else begin
        row_nxt[k] = rem_v[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fill_busy) begin
      for (int k = 0; k < WINDOW; k++) begin
        row_r[k] <= fill_value;
      end
    end else if (ctl.upd) begin
      for (int k = 0; k < WINDOW; k++) begin
        row_r[k] <= row_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < Scan; i++) begin
        lo_r[i] <= row_r[i];
        hi_r[i] <= row_r[WINDOW-1-i];
      end
    end else if (ctl.shift) begin
      for (int i = 0; i < Scan - 1; i++) begin
        lo_r[i] <= lo_r[i+1];
        hi_r[i] <= hi_r[i+1];
      end
    end
  end

  assign lo_head = lo_r[0];
  assign hi_head = hi_r[0];

endmodule

// ===== rtl/stmf_div.sv =====
// Bit-serial restoring divider producing the saturated Q.8 mean.
module stmf_div #(
  parameter int WINDOW      = stmf_pkg::DEF_WINDOW,
  parameter int SUM_W       = stmf_pkg::DEF_SAMPLE_BITS + $clog2(WINDOW) + 1,
  parameter int DIV_W       = $clog2(WINDOW + 1)
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [SUM_W-1:0]          dividend,
  input  logic [DIV_W-1:0]                 divisor,
  output logic                             done,
  output logic signed [stmf_pkg::OUT_W-1:0] quotient
);
  import stmf_pkg::*;

  localparam int NW  = SUM_W + FRAC_BITS;
  localparam int CW  = $clog2(NW + 1);
  localparam int QXW = (NW > OUT_W) ? NW + 1 : OUT_W + 1;

  logic [NW-1:0]    n_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] d_r;
  logic [CW-1:0]    cnt_r;
  logic             busy_r;
  logic             done_r;
  logic             neg_r;
  logic [SUM_W-1:0] mag;
  logic [DIV_W:0]   rem_sh;
  logic             qbit;
  logic [DIV_W:0]   rem_sub;
  logic [QXW-1:0]   qx;

  assign mag     = dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
  assign rem_sh  = {rem_r, n_r[NW-1]};
  assign qbit    = rem_sh >= {1'b0, d_r};
  assign rem_sub = rem_sh - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= {mag, {FRAC_BITS{1'b0}}};
      rem_r <= '0;
      d_r   <= divisor;
      neg_r <= dividend[SUM_W-1];
    end else if (busy_r) begin
      n_r   <= {n_r[NW-2:0], qbit};
      rem_r <= qbit ? rem_sub[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign qx = QXW'(n_r);

  always_comb begin
    if (neg_r) begin
      quotient = (qx > QXW'(2 ** (OUT_W - 1))) ? OUT_MIN : OUT_W'(QXW'(0) - qx);
    end else begin
      quotient = (qx > QXW'(2 ** (OUT_W - 1) - 1)) ? OUT_MAX : OUT_W'(qx);
    end
  end

  assign done = done_r;

endmodule

// ===== rtl/sliding_trimmed_mean_filter.sv =====
// Sliding trimmed mean filter: top level with sequencer, register port and output stage.
// An item passes from acceptance through the read, load, trim, divide and output states to its result;
// one item is in work at a time, so no new item is accepted until the last result is loaded out.
// The divider is bit-serial and produces one quotient bit per cycle.
// After reset, and after each write of the fill register, a sweep refills the window memory
// while no item is accepted.
`include "sliding_trimmed_mean_filter_defines.svh"

module sliding_trimmed_mean_filter #(
  parameter int WINDOW      = stmf_pkg::DEF_WINDOW,
  parameter int SAMPLE_BITS = stmf_pkg::DEF_SAMPLE_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  in_tdata,   // sample
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [stmf_pkg::OUT_W-1:0]        out_tdata,  // trimmed_mean
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [stmf_pkg::CFG_AW-1:0]       cfg_paddr,
  input  logic [stmf_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [stmf_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                              cfg_pready
);
  import stmf_pkg::*;

  localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW) + 1;
  localparam int DIV_W   = $clog2(WINDOW + 1);
  localparam int TrimLim = (WINDOW - 1) / 2;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_LOAD = 3'd2;
  localparam logic [2:0] ST_TRIM = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0]                    state_r;
  logic [2:0]                    state_nxt;
  logic [TRIM_W-1:0]             trim_r;
  logic signed [SAMPLE_BITS-1:0] fill_r;
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic signed [SUM_W-1:0]       kept_r;
  logic [TRIM_W-1:0]             cnt_r;
  logic [TRIM_W-1:0]             cut;
  logic [DIV_W-1:0]              divisor;
  logic                          out_tvalid_r;
  logic [OUT_W-1:0]              out_tdata_r;
  logic                          cfg_wr;
  logic                          accept;
  logic                          out_load;
  logic                          div_start;
  logic                          div_done;
  logic signed [OUT_W-1:0]       div_q;
  logic                          fill_busy;
  logic signed [SAMPLE_BITS-1:0] old_sample;
  logic signed [SUM_W-1:0]       sum;
  logic signed [SAMPLE_BITS-1:0] lo_head;
  logic signed [SAMPLE_BITS-1:0] hi_head;
  stmf_ctl_t                     ctl;

  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_FILL) ? CFG_DW'(fill_r) : CFG_DW'(trim_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trim_r <= TRIM_W'(1);
      fill_r <= '0;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_TRIM) begin
        trim_r <= cfg_pwdata[TRIM_W-1:0];
      end else begin
        fill_r <= cfg_pwdata[SAMPLE_BITS-1:0];
      end
    end
  end

  assign cut     = (trim_r > TRIM_W'(TrimLim)) ? TRIM_W'(TrimLim) : trim_r;
  assign divisor = DIV_W'(WINDOW) - DIV_W'({cut, 1'b0});

  assign in_tready = (state_r == ST_IDLE) & ~fill_busy;
  assign accept    = in_tvalid & in_tready;
  assign div_start = (state_r == ST_TRIM) & (cnt_r == '0);
  assign out_load  = (state_r == ST_OUT) & (~out_tvalid_r | out_tready);

  assign ctl.fill  = cfg_wr & (cfg_paddr[2] == REG_FILL);
  assign ctl.rd    = accept;
  assign ctl.upd   = state_r == ST_RD;
  assign ctl.load  = state_r == ST_LOAD;
  assign ctl.shift = (state_r == ST_TRIM) & (cnt_r != '0);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_TRIM;
      ST_TRIM: if (cnt_r == '0) state_nxt = ST_DIV;
      ST_DIV:  if (div_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample_r <= in_tdata[SAMPLE_BITS-1:0];
    end
    if (ctl.load) begin
      kept_r <= sum;
      cnt_r  <= cut;
    end else if (ctl.shift) begin
      kept_r <= kept_r - SUM_W'(lo_head) - SUM_W'(hi_head);
      cnt_r  <= cnt_r - 1'b1;
    end
    if (out_load) begin
      out_tdata_r <= div_q;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  stmf_window #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_W       (SUM_W)
  ) u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .fill_value (fill_r),
    .sample     (sample_r),
    .old_sample (old_sample),
    .sum        (sum),
    .fill_busy  (fill_busy)
  );

  stmf_sort #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_sort (
    .clk        (clk),
    .ctl        (ctl),
    .fill_busy  (fill_busy),
    .fill_value (fill_r),
    .old_sample (old_sample),
    .new_sample (sample_r),
    .lo_head    (lo_head),
    .hi_head    (hi_head)
  );

  stmf_div #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W),
    .DIV_W  (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (kept_r),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (div_q)
  );

  `STMF_ASSERT_NEXT(a_accept_reads, clk, rst_n, accept, state_r == ST_RD)
  `STMF_ASSERT_NOW(a_done_in_div, clk, rst_n, div_done, state_r == ST_DIV)
  `STMF_ASSERT_NEXT(a_cut_bound, clk, rst_n, state_r == ST_LOAD, cnt_r <= TRIM_W'(TrimLim))
  `STMF_ASSERT_NOW(a_no_item_in_sweep, clk, rst_n, state_r == ST_RD, !fill_busy)

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the sliding trimmed mean filter: directed table, then random traffic.
module testbench;
  import stmf_pkg::*;

  localparam int WIN = DEF_WINDOW;
  localparam int SW  = DEF_SAMPLE_BITS;
  localparam int DW  = ((DEF_SAMPLE_BITS + 7) / 8) * 8;
  localparam logic [CFG_AW-1:0] ADDR_TRIM = {REG_TRIM, 2'b00};
  localparam logic [CFG_AW-1:0] ADDR_FILL = {REG_FILL, 2'b00};
  localparam int DRAIN_CYCLES = 60;
  localparam int SEG_ITEMS = 66;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    logic [CFG_AW-1:0] addr;
    logic [31:0]       value;
    logic              typed;
    logic [OUT_W-1:0]  result;
  } plan_row_t;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [DW-1:0]     in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_W-1:0]  out_tdata;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  logic signed [SW-1:0] window_q [WIN];
  longint               window_sum;
  int unsigned          next_slot;
  logic [TRIM_W-1:0]    trim_reg;
  logic signed [SW-1:0] fill_reg;

  logic [OUT_W-1:0] mean_q [$];
  logic [OUT_W-1:0] wanted_mean;
  int errors;
  int samples_sent;
  int means_checked;
  int reg_writes;
  int send_idle_pct;
  int recv_idle_pct;

  plan_row_t plan [0:20] = '{
    '{ROW_ITEM,  ADDR_TRIM, 32'h0000_7FFF, 1'b1, 24'h000000},
    '{ROW_ITEM,  ADDR_TRIM, 32'h0000_8000, 1'b1, 24'h000000},
    '{ROW_ITEM,  ADDR_TRIM, 32'h0000_0001, 1'b0, 24'h000000},
    '{ROW_WRITE, ADDR_TRIM, 32'h0000_0000, 1'b0, 24'h000000},
    '{ROW_ITEM,  ADDR_TRIM, 32'h0000_0000, 1'b0, 24'h000000},
    '{ROW_WRITE, ADDR_FILL, 32'h0000_7FFF, 1'b0, 24'h000000},
    '{ROW_ITEM,  ADDR_TRIM, 32'h0000_7FFF, 1'b1, 24'h7FFF00},
    '{ROW_WRITE, ADDR_FILL, 32'h0000_8000, 1'b0, 24'h000000},
    '{ROW_ITEM,  ADDR_TRIM, 32'h0000_8000, 1'b1, 24'h800000},
    '{ROW_ITEM,  ADDR_TRIM, 32'h0000_7FFF, 1'b0, 24'h000000},
    '{ROW_WRITE, ADDR_TRIM, 32'h0000_0007, 1'b0, 24'h000000},
    '{ROW_ITEM,  ADDR_TRIM, 32'h0000_FFFF, 1'b0, 24'h000000},
    '{ROW_ITEM,  ADDR_TRIM, 32'h0000_7FFF, 1'b0, 24'h000000},
    '{ROW_WRITE, ADDR_FILL, 32'hA5A5_0001, 1'b0, 24'h000000},
    '{ROW_WRITE, ADDR_TRIM, 32'hFFFF_FFF5, 1'b0, 24'h000000},
    '{ROW_ITEM,  ADDR_TRIM, 32'h0000_FFFF, 1'b1, 24'h000100},
    '{ROW_ITEM,  ADDR_TRIM, 32'h0000_0002, 1'b0, 24'h000000},
    '{ROW_WRITE, ADDR_TRIM, 32'h0000_0003, 1'b0, 24'h000000},
    '{ROW_ITEM,  ADDR_TRIM, 32'h0000_5555, 1'b0, 24'h000000},
    '{ROW_ITEM,  ADDR_TRIM, 32'h0000_AAAA, 1'b0, 24'h000000},
    '{ROW_ITEM,  ADDR_TRIM, 32'h0000_FFFF, 1'b0, 24'h000000}
  };

  sliding_trimmed_mean_filter u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic void refill_window(input logic signed [SW-1:0] v);
    for (int i = 0; i < WIN; i++) window_q[i] = v;
    window_sum = longint'(v) * WIN;
  endfunction

  // Pushes one sample into the model window and returns the Q.8 trimmed mean.
  function automatic logic [OUT_W-1:0] advance_window(input logic signed [SW-1:0] s);
    longint      sorted [WIN];
    longint      x;
    longint      kept;
    longint      q;
    int          j;
    int unsigned cut;
    window_sum = window_sum - window_q[next_slot] + s;
    window_q[next_slot] = s;
    next_slot = (next_slot + 1) % WIN;
    for (int i = 0; i < WIN; i++) begin
      x = window_q[i];
      j = i;
      while (j > 0 && sorted[j-1] > x) begin
        sorted[j] = sorted[j-1];
        j--;
      end
      sorted[j] = x;
    end
    cut = (trim_reg > (WIN - 1) / 2) ? (WIN - 1) / 2 : trim_reg;
    kept = window_sum;
    for (int i = 0; i < cut; i++) kept = kept - sorted[i] - sorted[WIN-1-i];
    q = (kept * (1 << FRAC_BITS)) / longint'(WIN - 2 * cut);
    if (q > longint'(OUT_MAX)) q = longint'(OUT_MAX);
    if (q < longint'(OUT_MIN)) q = longint'(OUT_MIN);
    return q[OUT_W-1:0];
  endfunction

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (mean_q.size() == 0) begin
        $display("%0t: unexpected mean %h", $time, out_tdata);
        errors++;
      end else begin
        wanted_mean = mean_q.pop_front();
        means_checked++;
        if (out_tdata !== wanted_mean) begin
          $display("%0t: trimmed_mean expected %h actual %h", $time, wanted_mean, out_tdata);
          errors++;
        end
      end
    end
  end

  task automatic push_sample(input logic [SW-1:0] s, input bit typed,
                             input logic [OUT_W-1:0] typed_mean);
    logic [OUT_W-1:0] m;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    do @(posedge clk); while (!in_tready);
    m = advance_window(s);
    mean_q.push_back(typed ? typed_mean : m);
    samples_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (mean_q.size() != 0) @(posedge clk);
  endtask

  task automatic wait_quiet();
    stop_sending();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_access(input logic wr, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] wdata, output logic [CFG_DW-1:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= addr;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // The fill write starts a window refill, so the port waits it out before going on.
  task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [CFG_DW-1:0] value);
    logic [CFG_DW-1:0] rd;
    wait_quiet();
    reg_access(1'b1, addr, value, rd);
    if (addr == ADDR_TRIM) begin
      trim_reg = value[TRIM_W-1:0];
    end else begin
      fill_reg = value[SW-1:0];
      refill_window(fill_reg);
    end
    reg_writes++;
    repeat (DRAIN_CYCLES) @(posedge clk);
    reg_access(1'b0, ADDR_TRIM, '0, rd);
    if (rd[TRIM_W-1:0] !== trim_reg) begin
      $display("%0t: trim_count readback expected %h actual %h", $time, trim_reg, rd);
      errors++;
    end
    reg_access(1'b0, ADDR_FILL, '0, rd);
    if (rd[SW-1:0] !== fill_reg) begin
      $display("%0t: initial_fill readback expected %h actual %h", $time, fill_reg, rd);
      errors++;
    end
  endtask

  function automatic logic [SW-1:0] pick_sample(input logic [SW-1:0] prev);
    int r;
    r = $urandom_range(9);
    if (r <= 5) return SW'($urandom());
    if (r <= 7) return SW'(fill_reg + $urandom_range(128) - 64);
    if (r == 8) return $urandom_range(1) ? 16'h7FFF : 16'h8000;
    return prev;
  endfunction

  initial begin
    logic [SW-1:0]     s;
    logic [CFG_DW-1:0] v;
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    errors = 0;
    samples_sent = 0;
    means_checked = 0;
    reg_writes = 0;
    send_idle_pct = 38;
    recv_idle_pct = 68;
    trim_reg = 3'd1;
    fill_reg = '0;
    next_slot = 0;
    refill_window('0);
    s = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) write_reg(plan[i].addr, plan[i].value);
      else push_sample(plan[i].value[SW-1:0], plan[i].typed, plan[i].result);
    end

    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct = (mode == 0) ? 38 : (mode == 1) ? 68 : 0;
      recv_idle_pct = (mode == 0) ? 68 : (mode == 1) ? 38 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        v = $urandom();
        if (seg == 0) v[TRIM_W-1:0] = '0;
        if (seg == 1) v[TRIM_W-1:0] = TRIM_W'(TRIM_MAX);
        write_reg(ADDR_TRIM, v);
        v = $urandom();
        if (seg == 0) v[SW-1:0] = 16'h8000;
        if (seg == 1) v[SW-1:0] = 16'h7FFF;
        write_reg(ADDR_FILL, v);
        for (int k = 0; k < SEG_ITEMS; k++) begin
          if (k == 20 || $urandom_range(49) == 0) begin
            stop_sending();
            wait_drained();
          end
          s = pick_sample(s);
          push_sample(s, 1'b0, '0);
        end
      end
    end

    wait_quiet();
    $display("tb: %0d samples sent, %0d means checked, %0d register writes",
             samples_sent, means_checked, reg_writes);
    $display("tb: covered trim 0 to 7, fill extremes, and three stall patterns");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
